/* rtl/lrk_pkg.sv */
// Shared types and codes for the LRU-K frame replacer.
package lrk_pkg;

  // Number of frames covered; the beat fields below are sized for it
  localparam int FRAME_TOTAL = 16;

  // Command codes
  localparam logic [2:0] CMD_RECORD = 3'd0;
  localparam logic [2:0] CMD_SET_EV = 3'd1;
  localparam logic [2:0] CMD_CLR_EV = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_EVICT  = 3'd4;
  localparam logic [2:0] CMD_SIZE   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] HIST_K_RESET = 3'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] frame_no;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] victim_frame;
    logic [4:0] evictable_count;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;        // run a non-evict command on the input beat
    logic scan_clear;  // start an evict scan
    logic scan_issue;  // read one frame of the scan
    logic commit;      // apply the evict result and load the output
  } lrk_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } lrk_stat_t;

endpackage

/* rtl/lrk_if.sv */
// Valid/ready channel interfaces for the request and response beats.
interface lrk_req_if import lrk_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lrk_rsp_if import lrk_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/lrk_ctrl.sv */
// Sequencer for the LRU-K replacer: accepts beats and runs the evict scan.
module lrk_ctrl import lrk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_command,
  output logic       in_ready,
  input  lrk_stat_t  stat,
  output lrk_ctrl_t  ctrl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_command == CMD_EVICT) begin
            ctrl.scan_clear = 1'b1;
            state_nxt       = S_SCAN;
          end else begin
            ctrl.exec = 1'b1;
          end
        end
      end
      S_SCAN: begin
        ctrl.scan_issue = 1'b1;
        if (stat.scan_last) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.commit = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/lrk_dp.sv */
// Datapath: frame flags, history memory, scan compare and output register.
module lrk_dp import lrk_pkg::*; #(
  parameter int K_MAX      = 4,
  parameter int STAMP_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lrk_ctrl_t  ctrl,
  output lrk_stat_t  stat,
  input  in_beat_t   in_data,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data
);

  localparam int FW     = $clog2(FRAME_TOTAL);
  localparam int SLOT_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW     = $clog2(K_MAX + 1);
  localparam int KW     = (CW > 3) ? CW : 3;
  localparam int DW     = $clog2(2 * K_MAX + 1);
  localparam int TW     = $clog2(FRAME_TOTAL + 1);
  localparam int DEPTH  = FRAME_TOTAL * K_MAX;
  localparam int AW     = $clog2(DEPTH);

  // slot that is 'back' writes behind the head, modulo K_MAX
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] head,
                                                  input logic [KW-1:0] back);
    logic [DW-1:0] diff;
    diff = DW'(head) + DW'(K_MAX) - DW'(back);
    if (diff >= DW'(K_MAX)) diff = diff - DW'(K_MAX);
    return SLOT_W'(diff);
  endfunction

  function automatic logic [AW-1:0] hist_addr(input logic [FW-1:0] f,
                                              input logic [SLOT_W-1:0] s);
    return AW'(int'(f) * K_MAX + int'(s));
  endfunction

  // per-frame state
  logic              tracked_r [FRAME_TOTAL];
  logic              evict_r   [FRAME_TOTAL];
  logic [CW-1:0]     cnt_r     [FRAME_TOTAL];
  logic [SLOT_W-1:0] head_r    [FRAME_TOTAL];

  logic [STAMP_BITS-1:0] hist_mem [DEPTH];
  logic [STAMP_BITS-1:0] rd_k_r, rd_o_r;

  logic [2:0]            hist_k_r;
  logic [STAMP_BITS-1:0] stamp_r, stamp_nxt;
  logic [TW-1:0]         total_r, total_nxt;

  // scan pipeline
  logic [FW-1:0]         scan_idx_r;
  logic                  pipe_v_r, cand_v_r, cand_inf_r, cand_n0_r;
  logic [FW-1:0]         cand_f_r;
  logic                  found_r, best_inf_r;
  logic [FW-1:0]         best_f_r;
  logic [STAMP_BITS-1:0] best_kst_r, best_old_r;

  // output register
  logic       out_valid_r;
  out_beat_t  out_data_r;

  logic [KW-1:0] k_eff, k_raw;
  logic          in_range;
  logic [FW-1:0] fid_idx, idx;
  logic          trk, evb;
  logic [CW-1:0] cnt;
  logic [SLOT_W-1:0] hd;

  logic              ent_we, trk_n, ev_n;
  logic [CW-1:0]     cnt_n, base_cnt;
  logic [SLOT_W-1:0] hd_n, base_hd;
  logic              hd_we, mem_we, out_load;
  logic [AW-1:0]     mem_wa, rd_ka, rd_oa;
  logic [1:0]        st;
  logic [FW-1:0]     vic;
  logic              want_ev, cand_inf;
  logic [STAMP_BITS-1:0] old_c;
  logic              better;

  assign k_raw = KW'(hist_k_r);
  assign k_eff = (hist_k_r == 3'd0) ? KW'(1) :
                 (k_raw > KW'(K_MAX)) ? KW'(K_MAX) : k_raw;

  assign in_range = (32'(in_data.frame_no) < FRAME_TOTAL);
  assign fid_idx  = FW'(in_data.frame_no);
  assign idx      = ctrl.commit ? best_f_r : (ctrl.exec ? fid_idx : scan_idx_r);

  assign trk = tracked_r[idx];
  assign evb = evict_r[idx];
  assign cnt = cnt_r[idx];
  assign hd  = head_r[idx];

  assign cand_inf = KW'(cnt) < k_eff;
  assign rd_ka    = hist_addr(idx, slot_back(hd, k_eff));
  assign rd_oa    = hist_addr(idx, slot_back(hd, KW'(cnt)));

  always_comb begin
    ent_we    = 1'b0;
    trk_n     = trk;
    ev_n      = evb;
    cnt_n     = cnt;
    hd_n      = hd;
    hd_we     = 1'b0;
    mem_we    = 1'b0;
    base_cnt  = trk ? cnt : '0;
    base_hd   = trk ? hd : '0;
    mem_wa    = hist_addr(idx, base_hd);
    stamp_nxt = stamp_r;
    total_nxt = total_r;
    st        = ST_OK;
    vic       = '0;
    want_ev   = (in_data.command == CMD_SET_EV);
    if (ctrl.exec) begin
      if ((in_data.command inside {CMD_RECORD, CMD_SET_EV, CMD_CLR_EV, CMD_REMOVE}) &&
          !in_range) begin
        st = ST_RANGE;
      end else begin
        case (in_data.command)
          CMD_RECORD: begin
            mem_we = 1'b1;
            ent_we = 1'b1;
            hd_we  = 1'b1;
            trk_n  = 1'b1;
            ev_n   = trk ? evb : 1'b0;
            cnt_n  = (32'(base_cnt) < K_MAX) ? base_cnt + CW'(1) : base_cnt;
            hd_n   = (32'(base_hd) + 1 == K_MAX) ? '0 : base_hd + SLOT_W'(1);
            if (stamp_r != '1) stamp_nxt = stamp_r + STAMP_BITS'(1);
          end
          CMD_SET_EV, CMD_CLR_EV: begin
            if (!trk) begin
              st = ST_MISS;
            end else if (evb != want_ev) begin
              ent_we = 1'b1;
              ev_n   = want_ev;
              if (want_ev) total_nxt = total_r + TW'(1);
              else if (total_r != '0) total_nxt = total_r - TW'(1);
            end
          end
          CMD_REMOVE: begin
            if (!trk || !evb) begin
              st = ST_MISS;
            end else begin
              ent_we = 1'b1;
              trk_n  = 1'b0;
              ev_n   = 1'b0;
              cnt_n  = '0;
              if (total_r != '0) total_nxt = total_r - TW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (ctrl.commit) begin
      if (found_r) begin
        ent_we = 1'b1;
        trk_n  = 1'b0;
        ev_n   = 1'b0;
        cnt_n  = '0;
        vic    = best_f_r;
        if (total_r != '0) total_nxt = total_r - TW'(1);
      end else begin
        st = ST_MISS;
      end
    end
  end

  assign out_load = ctrl.exec || ctrl.commit;

  // scan compare: same clock for all, so a larger distance is an older k-th stamp
  assign old_c = cand_n0_r ? '0 : rd_o_r;
  always_comb begin
    if (!found_r) better = 1'b1;
    else if (cand_inf_r != best_inf_r) better = cand_inf_r;
    else if (!cand_inf_r && (rd_k_r != best_kst_r)) better = rd_k_r < best_kst_r;
    else better = old_c < best_old_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_wa] <= stamp_r;
    rd_k_r <= hist_mem[rd_ka];
    rd_o_r <= hist_mem[rd_oa];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_TOTAL; i++) begin
        tracked_r[i] <= 1'b0;
        evict_r[i]   <= 1'b0;
        cnt_r[i]     <= '0;
      end
      hist_k_r    <= HIST_K_RESET;
      stamp_r     <= STAMP_BITS'(1);
      total_r     <= '0;
      pipe_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) hist_k_r <= cfg_wr_data;
      if (ent_we) begin
        tracked_r[idx] <= trk_n;
        evict_r[idx]   <= ev_n;
        cnt_r[idx]     <= cnt_n;
      end
      stamp_r  <= stamp_nxt;
      total_r  <= total_nxt;
      pipe_v_r <= ctrl.scan_issue;
      if (ctrl.scan_clear) found_r <= 1'b0;
      else if (pipe_v_r && cand_v_r && better) found_r <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) head_r[idx] <= hd_n;
    if (ctrl.scan_clear) scan_idx_r <= '0;
    else if (ctrl.scan_issue) scan_idx_r <= scan_idx_r + FW'(1);
    if (ctrl.scan_issue) begin
      cand_v_r   <= trk && evb;
      cand_inf_r <= cand_inf;
      cand_n0_r  <= (cnt == '0);
      cand_f_r   <= idx;
    end
    if (pipe_v_r && cand_v_r && better) begin
      best_f_r   <= cand_f_r;
      best_inf_r <= cand_inf_r;
      best_kst_r <= rd_k_r;
      best_old_r <= old_c;
    end
    if (out_load) begin
      out_data_r.status          <= st;
      out_data_r.victim_frame    <= 4'(vic);
      out_data_r.evictable_count <= 5'(total_nxt);
    end
  end

  assign stat.scan_last = (scan_idx_r == FW'(FRAME_TOTAL - 1));
  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

/* rtl/lru_k_frame_replacer.sv */
// Top level of the LRU-K frame replacer: sequencer plus datapath.
//
// Usage
//   in_chan  : request beats {command, frame_no}, valid/ready.
//   out_chan : one response beat {status, victim_frame, evictable_count}
//              per request, valid/ready, in request order.
//   cfg_*    : write of history_k (k); only while no request is in flight.
// Timing / throughput
//   Record, flag, remove and size commands: the response is registered at
//   the accepting edge and shows the next cycle; one beat per cycle unless stalled.
//   Evict: the scan reads one frame per cycle from the history memory (two
//   read ports: k-th stamp and oldest kept stamp), then passes a compare
//   state and a commit state that waits for a free output register.
// Reset (rst_n low, synchronous): no frame tracked, count zero, clock stamp
//   one, k = 2. History memory is not cleared; entries are only read after
//   they have been written.
// Stall: a response waits in the output register while out_chan.ready is
//   low; a new request is taken once that register is free or draining and no evict is running.
module lru_k_frame_replacer import lrk_pkg::*; #(
  parameter int K_MAX      = 4,
  parameter int STAMP_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lrk_req_if.sink    in_chan,
  lrk_rsp_if.source  out_chan,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  lrk_ctrl_t ctrl;
  lrk_stat_t stat;

  // sequencer: owns handshake on the request side and the scan timing
  lrk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.data.command),
    .in_ready   (in_chan.ready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  // datapath: frame state, stamps, victim search and response register
  lrk_dp #(
    .K_MAX      (K_MAX),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_data     (in_chan.data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_data    (out_chan.data)
  );

endmodule
